// ----- rtl/krle_pkg.sv -----
package krle_pkg;

    // Key and countdown sizing
    localparam int NUM_KEYS  = 7;
    localparam int KEY_W     = 7;
    localparam int CD_W      = 8;
    localparam int NUM_LANES = (NUM_KEYS < KEY_W) ? NUM_KEYS : KEY_W;

    // Fixed key positions
    localparam int NUM_ARROWS = 4;
    localparam int KEY_OK_IDX = 4;

    // Register reset values
    localparam logic [CD_W-1:0] FIRST_REPEAT_RST = CD_W'(25);
    localparam logic [CD_W-1:0] REPEAT_INTV_RST  = CD_W'(10);
    localparam logic [CD_W-1:0] LONG_PRESS_RST   = CD_W'(100);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_REPEAT = 2'd0,
        CFG_REPEAT_INTV  = 2'd1,
        CFG_LONG_PRESS   = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_ARROW,
        KIND_OK,
        KIND_LONG
    } key_kind_t;

    typedef struct packed {
        logic [CD_W-1:0] first_repeat_delay;
        logic [CD_W-1:0] repeat_interval;
        logic [CD_W-1:0] long_press_delay;
    } cfg_t;

    typedef struct packed {
        logic pressed;
        logic released;
        logic longp;
    } key_evt_t;

    function automatic key_kind_t lane_kind(input int k);
        key_kind_t kind;
        if (k < NUM_ARROWS)
            kind = KIND_ARROW;
        else if (k == KEY_OK_IDX)
            kind = KIND_OK;
        else
            kind = KIND_LONG;
        return kind;
    endfunction

endpackage

// ----- rtl/krle_lane.sv -----
// One key: edge detect plus countdown.
module krle_lane
    import krle_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  key_kind_t kind,
    input  cfg_t      cfg,
    input  logic      take,
    input  logic      key_now,
    input  logic      key_prev,
    output key_evt_t  evt
);

    logic [CD_W-1:0] cd_reg;
    logic [CD_W-1:0] cd_next;
    logic [CD_W-1:0] cd_load;
    logic            rise;
    logic            fall;
    logic            held;
    logic            counts;
    logic            expire;

    always_comb
    begin
        rise = key_now & ~key_prev;
        fall = ~key_now & key_prev;

        // press loads the countdown before the held check
        if (rise)
            cd_load = (kind == KIND_ARROW) ? cfg.first_repeat_delay : cfg.long_press_delay;
        else
            cd_load = cd_reg;

        held   = key_now && (cd_load != '0);
        counts = held && (kind != KIND_OK);
        expire = counts && (cd_load == CD_W'(1));

        if (expire && (kind == KIND_ARROW))
            cd_next = cfg.repeat_interval;
        else if (counts)
            cd_next = cd_load - CD_W'(1);
        else
            cd_next = cd_load;

        evt.pressed  = rise || (expire && (kind == KIND_ARROW));
        evt.released = fall && (kind != KIND_ARROW) && (cd_load != '0);
        evt.longp    = expire && (kind == KIND_LONG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cd_reg <= '0;
        else if (take)
            cd_reg <= cd_next;
    end

endmodule

// ----- rtl/krle_merge.sv -----
// Gathers lane events into masks; output register with its valid.
module krle_merge
    import krle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  key_evt_t         lane_evt [NUM_LANES],
    input  logic             take,
    input  logic             out_ready,
    output logic             stage_free,
    output logic             out_valid,
    output logic [KEY_W-1:0] pressed_mask,
    output logic [KEY_W-1:0] released_mask,
    output logic [KEY_W-1:0] long_mask,
    output logic             any_event
);

    logic             valid_reg;
    logic             valid_next;
    logic [KEY_W-1:0] pressed_reg;
    logic [KEY_W-1:0] released_reg;
    logic [KEY_W-1:0] long_reg;
    logic             any_reg;
    logic [KEY_W-1:0] pressed_next;
    logic [KEY_W-1:0] released_next;
    logic [KEY_W-1:0] long_next;

    always_comb
    begin
        pressed_next  = '0;
        released_next = '0;
        long_next     = '0;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            pressed_next[k]  = lane_evt[k].pressed;
            released_next[k] = lane_evt[k].released;
            long_next[k]     = lane_evt[k].longp;
        end
    end

    assign stage_free = !valid_reg || out_ready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            long_reg     <= long_next;
            any_reg      <= |{pressed_next, released_next, long_next};
        end
    end

    assign out_valid     = valid_reg;
    assign pressed_mask  = pressed_reg;
    assign released_mask = released_reg;
    assign long_mask     = long_reg;
    assign any_event     = any_reg;

endmodule

// ----- rtl/key_repeat_longpress_events.sv -----
// Channel | Signals                               | Direction | Accepted when
// in      | in_valid, in_ready, keys_now          | into blk  | in_valid & in_ready
// out     | out_valid, out_ready, *_mask, any_ev. | out of blk| out_valid & out_ready
// cfg     | cfg_we, cfg_index, cfg_wdata          | into blk  | cfg_we
//
// One beat in per cycle sustained while out_ready is high; its result appears in the
// output register in the next cycle. All seven key lanes evaluate in parallel.
// in_ready stays high while the output register is empty or being drained,
// so a stalled consumer backs up the input after one buffered result.
// Reset (async, active low) clears previous levels, countdowns and out_valid;
// config registers return to 25 / 10 / 100.
module key_repeat_longpress_events
    import krle_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KEY_W-1:0]     keys_now,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [KEY_W-1:0]     pressed_mask,
    output logic [KEY_W-1:0]     released_mask,
    output logic [KEY_W-1:0]     long_mask,
    output logic                 any_event,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CD_W-1:0]      cfg_wdata
);

    cfg_t             cfg_reg;
    logic [KEY_W-1:0] prev_keys_reg;
    logic             take;
    logic             stage_free;
    key_evt_t         lane_evt [NUM_LANES];

    assign in_ready = stage_free;
    assign take     = in_valid && stage_free;

    // Config writes; an unused index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_repeat_delay <= FIRST_REPEAT_RST;
            cfg_reg.repeat_interval    <= REPEAT_INTV_RST;
            cfg_reg.long_press_delay   <= LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FIRST_REPEAT: cfg_reg.first_repeat_delay <= cfg_wdata;
                CFG_REPEAT_INTV:  cfg_reg.repeat_interval    <= cfg_wdata;
                CFG_LONG_PRESS:   cfg_reg.long_press_delay   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Previous levels, updated per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_keys_reg <= '0;
        else if (take)
            prev_keys_reg <= keys_now;
    end

    // One lane per key; kind fixed by position (arrow, OK, long-press).
    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        krle_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .kind     (lane_kind(k)),
            .cfg      (cfg_reg),
            .take     (take),
            .key_now  (keys_now[k]),
            .key_prev (prev_keys_reg[k]),
            .evt      (lane_evt[k])
        );
    end

    krle_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .lane_evt      (lane_evt),
        .take          (take),
        .out_ready     (out_ready),
        .stage_free    (stage_free),
        .out_valid     (out_valid),
        .pressed_mask  (pressed_mask),
        .released_mask (released_mask),
        .long_mask     (long_mask),
        .any_event     (any_event)
    );

endmodule

// ----- rtl/krle_checker.sv -----
module krle_checker
    import krle_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [KEY_W-1:0]     pressed_mask,
    input logic [KEY_W-1:0]     released_mask,
    input logic [KEY_W-1:0]     long_mask,
    input logic                 any_event
);

    // held result must not change under a stall
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pressed_mask)
        && $stable(released_mask) && $stable(long_mask) && $stable(any_event))
        else $error("output beat changed while stalled");

    a_any: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> any_event == (|{pressed_mask, released_mask, long_mask}))
        else $error("any_event disagrees with masks");

    // arrows and OK never long-press; arrows never release
    a_key_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> long_mask[KEY_OK_IDX:0] == '0
        && released_mask[NUM_ARROWS-1:0] == '0)
        else $error("event on key of wrong kind");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not track output register");

    // every accepted beat yields a result next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

endmodule

bind key_repeat_longpress_events krle_checker u_krle_checker (.*);
